// ===== rtl/page_translation_table_defines.svh =====
// Assertion macros shared by the page translation table RTL.
`ifndef PAGE_TRANSLATION_TABLE_DEFINES_SVH
`define PAGE_TRANSLATION_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PTT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page table check failed");

// Next-cycle implication, checked outside reset.
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page table sequencing check failed");

`endif

// ===== rtl/ptt_pkg.sv =====
// Shared types and codes for the page translation table.
`default_nettype none

package ptt_pkg;

  // Operation codes carried in the mode field
  localparam logic [2:0] MODE_ADD       = 3'd0;
  localparam logic [2:0] MODE_DEL_VIRT  = 3'd1;
  localparam logic [2:0] MODE_DEL_PHYS  = 3'd2;
  localparam logic [2:0] MODE_FIND_VIRT = 3'd3;
  localparam logic [2:0] MODE_FIND_PHYS = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  // Configuration register indexes
  localparam logic REG_MAX_ENTRIES = 1'b0;

  localparam logic [6:0] MAX_ENTRIES_RESET = 7'd64;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] found_index;
    logic [6:0] entry_total;
  } out_beat_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic load;      // write the new pair into this cell
    logic shift;     // take the pair from the cell above
    logic cmp;       // capture the compare result
    logic use_phys;  // compare against the physical address
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ptt_cell.sv =====
// One table cell: holds a virtual/physical pair and compares it with the key.
`default_nettype none

module ptt_cell
  import ptt_pkg::*;
#(
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire cell_ctl_t             ctl,
  input  wire logic                  live,
  input  wire logic [ADDR_WIDTH-1:0] key,
  input  wire logic [ADDR_WIDTH-1:0] new_virt,
  input  wire logic [ADDR_WIDTH-1:0] new_phys,
  input  wire logic [ADDR_WIDTH-1:0] up_virt,
  input  wire logic [ADDR_WIDTH-1:0] up_phys,
  output logic      [ADDR_WIDTH-1:0] virt,
  output logic      [ADDR_WIDTH-1:0] phys,
  output logic                       hit
);

  // Load a new pair or take the neighbor's pair on a compaction
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      virt <= new_virt;
      phys <= new_phys;
    end else if (ctl.shift) begin
      virt <= up_virt;
      phys <= up_phys;
    end
  end

  // Capture the match against the key; dead cells never hit
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      hit <= live && ((ctl.use_phys ? phys : virt) == key);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptt_scan.sv =====
// Lowest-hit scan: prefix OR over the hit row and index of the first hit.
`default_nettype none

module ptt_scan
  import ptt_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  wire logic [DEPTH-1:0] hit,
  output logic      [DEPTH-1:0] at_or_above,
  output logic                  any_hit,
  output logic      [IW-1:0]    first_idx
);

  logic [DEPTH-1:0] first;

  // Log-depth prefix OR: bit i set when some cell at or below i hits
  always_comb begin
    at_or_above = hit;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      at_or_above = at_or_above | (at_or_above << s);
    end
  end

  assign first   = hit & ~(at_or_above << 1);
  assign any_hit = at_or_above[DEPTH-1];

  // Encode the single first-hit bit
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        first_idx = first_idx | IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/page_translation_table.sv =====
// Page translation table: row of address-pair cells with ordered compaction.
// Sequencing: an accepted beat is compared in the next cycle and resolved in the
// resolve state that follows; its result is registered onto out_data at commit.
// A new beat is accepted only in idle, once the accept/compare/resolve sequencer
// has resolved the last one; resolve waits while an earlier result is stalled.
// Reset (rst, synchronous): entry count zero, max_entries 64, no result held.
`default_nettype none
`include "page_translation_table_defines.svh"

module page_translation_table
  import ptt_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_beat_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int LW = (CW > 7) ? CW : 7;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_RES  = 3'b100
  } state_t;

  state_t                state, state_next;
  logic [6:0]            max_entries;
  logic [CW-1:0]         count, count_next;
  logic [2:0]            op_mode;
  logic [ADDR_WIDTH-1:0] op_virt, op_phys, key;

  logic [DEPTH-1:0]      hit, at_or_above;
  logic                  any_hit;
  logic [IW-1:0]         first_idx;
  logic [ADDR_WIDTH-1:0] virt [DEPTH];
  logic [ADDR_WIDTH-1:0] phys [DEPTH];

  logic                  commit, full, is_add, is_del, is_find;
  logic [LW-1:0]         limit;
  logic [1:0]            status_next;
  logic [IW-1:0]         index_next;

  // Register port: one register, max_entries, at byte address 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? {25'd0, max_entries} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_ENTRIES)) begin
      max_entries <= pwdata[6:0];
    end
  end

  // Sequencer
  assign in_stall = (state != S_IDLE);
  assign commit   = (state == S_RES) && !(out_valid && out_stall);

  always_comb begin
    case (state)
      S_IDLE:  state_next = (in_valid) ? S_CMP : S_IDLE;
      S_CMP:   state_next = S_RES;
      S_RES:   state_next = commit ? S_IDLE : S_RES;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the beat, addresses masked to the table width
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_mode <= in_data.mode;
      op_virt <= ADDR_WIDTH'(in_data.virt_addr);
      op_phys <= ADDR_WIDTH'(in_data.phys_addr);
    end
  end

  assign is_add  = (op_mode == MODE_ADD);
  assign is_del  = (op_mode == MODE_DEL_VIRT) || (op_mode == MODE_DEL_PHYS);
  assign is_find = (op_mode == MODE_FIND_VIRT) || (op_mode == MODE_FIND_PHYS);
  assign key     = (op_mode == MODE_DEL_PHYS || op_mode == MODE_FIND_PHYS)
                   ? op_phys : op_virt;

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t             ctl;
    logic [ADDR_WIDTH-1:0] up_virt, up_phys;

    if (i == DEPTH - 1) begin : g_top
      assign up_virt = '0;
      assign up_phys = '0;
      assign ctl.shift = 1'b0;
    end else begin : g_mid
      assign up_virt = virt[i+1];
      assign up_phys = phys[i+1];
      assign ctl.shift = commit && is_del && any_hit && at_or_above[i];
    end

    assign ctl.load     = commit && is_add && !full && (count == CW'(i));
    assign ctl.cmp      = (state == S_CMP);
    assign ctl.use_phys = (op_mode == MODE_DEL_PHYS) || (op_mode == MODE_FIND_PHYS);

    ptt_cell #(
      .ADDR_WIDTH(ADDR_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .live    (CW'(i) < count),
      .key     (key),
      .new_virt(op_virt),
      .new_phys(op_phys),
      .up_virt (up_virt),
      .up_phys (up_phys),
      .virt    (virt[i]),
      .phys    (phys[i]),
      .hit     (hit[i])
    );
  end

  ptt_scan #(
    .DEPTH(DEPTH),
    .IW   (IW)
  ) u_scan (
    .hit        (hit),
    .at_or_above(at_or_above),
    .any_hit    (any_hit),
    .first_idx  (first_idx)
  );

  // Resolve: limit is the smaller of max_entries and the table depth
  assign limit = (LW'(max_entries) < LW'(DEPTH)) ? LW'(max_entries) : LW'(DEPTH);
  assign full  = (LW'(count) >= limit);

  always_comb begin
    count_next  = count;
    status_next = ST_MISS;
    index_next  = '0;
    if (is_add) begin
      if (full) begin
        count_next  = (count != '0) ? count - CW'(1) : count;
        status_next = ST_FULL;
      end else begin
        count_next  = count + CW'(1);
        status_next = ST_OK;
        index_next  = IW'(count);
      end
    end else if (is_del) begin
      if (any_hit) begin
        count_next  = count - CW'(1);
        status_next = ST_OK;
        index_next  = first_idx;
      end
    end else if (is_find) begin
      if (any_hit) begin
        status_next = ST_OK;
        index_next  = first_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  // Output register: hold while stalled, drop on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data.status      <= status_next;
      out_data.found_index <= 6'(index_next);
      out_data.entry_total <= 7'(count_next);
    end
  end

  // Checks
  `PTT_ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `PTT_ASSERT_NEXT(a_accept_to_cmp, in_valid && !in_stall, state == S_CMP)
  `PTT_ASSERT_NEXT(a_commit_shows, commit, out_valid && state == S_IDLE)
  `PTT_ASSERT_IMPL(a_add_fits, commit && is_add && !full, count < CW'(DEPTH))

endmodule

`default_nettype wire

// ===== sim/page_translation_table_checker.sv =====
// Checker for the page translation table: predicts every result beat and compares it.
module page_translation_table_checker
  import ptt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire in_beat_t    in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire out_beat_t   out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic [31:0] prdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending,
  output int               checked,
  output int               hit_count,
  output int               full_count,
  output int               peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] LIMIT_ADDR = {REG_MAX_ENTRIES, 2'b00};

  // Shadow copy of the table, its fill level and the entry limit register
  logic [31:0] virt_tab [DEPTH];
  logic [31:0] phys_tab [DEPTH];
  int          held;
  logic [6:0]  cap_reg;

  out_beat_t   expected_q [$];

  int errors   = 0;
  int n_checked = 0;
  int n_hits   = 0;
  int n_full   = 0;
  int n_peak   = 0;

  // Lowest occupied position holding key, or -1
  function automatic int lowest_match(input logic use_phys, input logic [31:0] key);
    for (int i = 0; i < held; i++) begin
      if ((use_phys ? phys_tab[i] : virt_tab[i]) == key) return i;
    end
    return -1;
  endfunction

  // Apply one operation to the shadow table and return the result it must produce
  function automatic out_beat_t translate(input in_beat_t op);
    out_beat_t res;
    int        limit;
    int        pos;
    logic      use_phys;
    res.status      = ST_MISS;
    res.found_index = '0;
    limit    = (int'(cap_reg) < DEPTH) ? int'(cap_reg) : DEPTH;
    use_phys = (op.mode == MODE_DEL_PHYS) || (op.mode == MODE_FIND_PHYS);
    case (op.mode)
      MODE_ADD: begin
        if (held >= limit) begin
          // refused add still drops the count, saturating at zero
          if (held > 0) held--;
          res.status = ST_FULL;
        end else begin
          virt_tab[held]  = op.virt_addr;
          phys_tab[held]  = op.phys_addr;
          res.found_index = 6'(held);
          held++;
          res.status = ST_OK;
        end
      end
      MODE_DEL_VIRT, MODE_DEL_PHYS: begin
        pos = lowest_match(use_phys, use_phys ? op.phys_addr : op.virt_addr);
        if (pos >= 0) begin
          // compact everything above the hit down by one
          for (int i = pos; i + 1 < held; i++) begin
            virt_tab[i] = virt_tab[i + 1];
            phys_tab[i] = phys_tab[i + 1];
          end
          held--;
          res.found_index = 6'(pos);
          res.status      = ST_OK;
        end
      end
      MODE_FIND_VIRT, MODE_FIND_PHYS: begin
        pos = lowest_match(use_phys, use_phys ? op.phys_addr : op.virt_addr);
        if (pos >= 0) begin
          res.found_index = 6'(pos);
          res.status      = ST_OK;
        end
      end
      default: ;
    endcase
    res.entry_total = 7'(held);
    return res;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      held    = 0;
      cap_reg = MAX_ENTRIES_RESET;
      expected_q.delete();
    end else begin
      // Compare an accepted result beat with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: status %0d found_index %0d entry_total %0d",
                 out_data.status, out_data.found_index, out_data.entry_total);
          errors++;
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d",
                   want.found_index, out_data.found_index);
            errors++;
          end
          if (out_data.entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, got %0d",
                   want.entry_total, out_data.entry_total);
            errors++;
          end
        end
      end

      // Predict the result of an accepted operation beat
      if (in_valid && !in_stall) begin
        want = translate(in_data);
        if (want.status == ST_OK && in_data.mode != MODE_ADD) n_hits++;
        if (want.status == ST_FULL) n_full++;
        if (held > n_peak) n_peak = held;
        expected_q.push_back(want);
      end

      // Track writes to the limit register and check reads of it
      if (psel && penable && pready && paddr == LIMIT_ADDR) begin
        if (pwrite) begin
          cap_reg = pwdata[6:0];
        end else if (prdata !== {25'd0, cap_reg}) begin
          $error("max_entries: expected %0d, got %0d", cap_reg, prdata);
          errors++;
        end
      end
    end

    fail_count <= errors;
    pending    <= expected_q.size();
    checked    <= n_checked;
    hit_count  <= n_hits;
    full_count <= n_full;
    peak_fill  <= n_peak;
  end

endmodule

// ===== sim/page_translation_table_test.sv =====
// Top of the page translation table testbench: clock, reset, stimulus and verdict.
module page_translation_table_test
  import ptt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] LIMIT_ADDR     = {REG_MAX_ENTRIES, 2'b00};
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         SETTLE_CYCLES  = 6;
  localparam int         PHASE_OPS      = 170;
  localparam int         ADDR_POOL      = 12;
  localparam int         PHASES         = 10;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, checked, hit_count, full_count, peak_fill;

  in_beat_t    op_queue [$];
  logic [31:0] virt_pool [ADDR_POOL];
  logic [31:0] phys_pool [ADDR_POOL];
  logic [6:0]  limit_plan [PHASES];
  int          burst_left = 0;
  int          n_settings = 0;

  page_translation_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  page_translation_table_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .hit_count  (hit_count),
    .full_count (full_count),
    .peak_fill  (peak_fill)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver backpressure: switch between stall patterns every so often
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  logic [3:0]  stall_tick = '0;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 4'd1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= stall_tick[2] & ~stall_tick[0];
    endcase
  end

  // Watchdog: end the run when nothing moves for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[page_translation_table] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void queue_op(input logic [2:0] mode, input logic [31:0] va,
                                   input logic [31:0] pa);
    in_beat_t b;
    b.mode      = mode;
    b.virt_addr = va;
    b.phys_addr = pa;
    op_queue.push_back(b);
  endfunction

  // Mostly addresses from a small pool so adds, removes and searches collide
  function automatic logic [31:0] pick_addr(input logic use_phys);
    if ($urandom_range(0, 6) == 0) return $urandom;
    return use_phys ? phys_pool[$urandom_range(0, ADDR_POOL - 1)]
                    : virt_pool[$urandom_range(0, ADDR_POOL - 1)];
  endfunction

  function automatic void refill_pools();
    foreach (virt_pool[i]) begin
      virt_pool[i] = $urandom;
      phys_pool[i] = $urandom;
    end
    virt_pool[0] = '0;
    virt_pool[1] = '1;
    phys_pool[0] = '1;
    phys_pool[1] = '0;
  endfunction

  function automatic void queue_random_op(input int add_pct);
    logic [2:0] mode;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) begin
      mode = MODE_ADD;
    end else if (roll >= 96) begin
      // unused codes above the last operation
      mode = MODE_FIND_PHYS + 3'($urandom_range(1, 3));
    end else begin
      case ($urandom_range(0, 3))
        0:       mode = MODE_DEL_VIRT;
        1:       mode = MODE_DEL_PHYS;
        2:       mode = MODE_FIND_VIRT;
        default: mode = MODE_FIND_PHYS;
      endcase
    end
    queue_op(mode, pick_addr(1'b0), pick_addr(1'b1));
  endfunction

  // Send queued beats in bursts with random gaps; drop valid when the queue empties
  task automatic drive_queued();
    in_beat_t b;
    int       gap;
    while (op_queue.size() != 0) begin
      b = op_queue.pop_front();
      in_valid <= 1'b1;
      in_data  <= b;
      do @(posedge clk); while (in_stall);
      if (burst_left > 0) burst_left--;
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap != 0 || op_queue.size() == 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Let every outstanding result come back, then give the pipeline time to empty
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic is_write, input logic [6:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= LIMIT_ADDR;
    pwdata  <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the entry limit while idle and read it back
  task automatic set_limit(input logic [6:0] value);
    wait_drained();
    apb_access(1'b1, value);
    apb_access(1'b0, value);
    n_settings++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty table: lookups and removes miss, unused code changes nothing
    queue_op(MODE_FIND_VIRT, 32'h0000_0000, 32'h0000_0000);
    queue_op(MODE_DEL_PHYS, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_op(MODE_FIND_PHYS + 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Extreme addresses and duplicates on both sides
    queue_op(MODE_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_op(MODE_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_op(MODE_ADD, 32'h1234_5678, 32'h9ABC_DEF0);
    queue_op(MODE_ADD, 32'h1234_5678, 32'h0000_0000);
    queue_op(MODE_FIND_VIRT, 32'h1234_5678, 32'h0000_0000);
    queue_op(MODE_FIND_PHYS, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_op(MODE_FIND_PHYS, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_op(MODE_FIND_VIRT, 32'hFFFF_FFFF, 32'h5555_5555);
    // Remove from the middle, then check the compacted order
    queue_op(MODE_DEL_VIRT, 32'h1234_5678, 32'h0000_0000);
    queue_op(MODE_FIND_PHYS, 32'hAAAA_AAAA, 32'h0000_0000);
    queue_op(MODE_DEL_PHYS, 32'hAAAA_AAAA, 32'h0000_0000);
    queue_op(MODE_FIND_VIRT, 32'h1234_5678, 32'h5555_5555);
    queue_op(MODE_FIND_PHYS + 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Remove the bottom entry
    queue_op(MODE_DEL_VIRT, 32'h0000_0000, 32'h5555_5555);
    queue_op(MODE_FIND_VIRT, 32'h5555_5555, 32'hAAAA_AAAA);
    drive_queued();

    // Limit of one: add at the limit is refused and the count drops
    set_limit(7'd1);
    queue_op(MODE_ADD, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    queue_op(MODE_ADD, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    queue_op(MODE_ADD, 32'h0BAD_F00D, 32'h0000_0001);
    drive_queued();

    // Limit of zero: every add is refused, count saturates at zero
    set_limit(7'd0);
    queue_op(MODE_ADD, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_op(MODE_FIND_VIRT, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    drive_queued();

    // Random phases alternate between filling and draining the table
    limit_plan = '{7'd64, 7'd127, 7'd127, 7'd2, 7'($urandom_range(3, 63)),
                   7'd1, 7'd64, 7'd0, 7'($urandom_range(3, 63)), 7'd64};
    foreach (limit_plan[p]) begin
      set_limit(limit_plan[p]);
      refill_pools();
      for (int k = 0; k < PHASE_OPS; k++) begin
        queue_random_op((p % 2 == 0) ? 70 : 35);
      end
      drive_queued();
    end

    wait_drained();
    $display("%0d operations checked over %0d limit settings", checked, n_settings);
    $display("%0d lookups hit, %0d adds refused, table held up to %0d entries",
             hit_count, full_count, peak_fill);
    if (fail_count == 0) begin
      $display("[page_translation_table] OK");
    end else begin
      $display("[page_translation_table] ERROR");
    end
    $finish;
  end

endmodule
